// ===== rtl/ulp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulp_pkg
// Shared types and constants for the serial LED/PWM command parser.
// ----------------------------------------------------------------------------
package ulp_pkg;

    // Decoded command handed from the parser to the responder
    typedef enum logic [2:0] {
        CMD_ON,
        CMD_OFF,
        CMD_STATUS,
        CMD_PWM_SET,
        CMD_PWM_ERR,
        CMD_UNKNOWN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [6:0]  value;   // new duty for a PWM set
    } t_cmd;

    // Responder sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } t_back_state;

    // Character codes
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DIG0 = 8'h30;
    localparam logic [7:0] CH_DIG9 = 8'h39;

    // Duty limits
    localparam logic [6:0] DUTY_RESET = 7'd50;
    localparam logic [6:0] DUTY_MAX   = 7'd100;

    // Keyword candidate bits
    localparam int KB_ON     = 0;
    localparam int KB_OFF    = 1;
    localparam int KB_STATUS = 2;
    localparam int KB_PWM    = 3;
    localparam logic [3:0] KW_ALL = 4'b1111;

endpackage : ulp_pkg
`default_nettype wire

// ===== rtl/uart_led_pwm_command_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: a '!' beat is queued at its accepting edge; an idle responder then pops it, and
//   the first response beat is registered once the output slot is free.
// Throughput: one rx beat per cycle while the two-entry queue has room; a response of
//   N bytes (at most 21) goes out one byte per beat, set by the text sequencer, and the
//   responder pops the next command only after its last byte. Other bytes give no output.
// Reset: synchronous active-low; clears parse state, queue, LED off, duty 50.
// ----------------------------------------------------------------------------
// uart_led_pwm_command_parser_top
// Serial command parser for an LED with PWM dimming: parser front end,
// command queue and response sequencer.
// ----------------------------------------------------------------------------
module uart_led_pwm_command_parser_top #(
    parameter int MAX_CMD_CHARS = 31,
    parameter int DUTY_SCALE    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_tx_valid,
    input  wire logic          i_tx_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte,
    output logic               o_led_is_on,
    output logic [6:0]         o_duty_percent,
    output logic [9:0]         o_compare_value
);
    import ulp_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    ulp_front #(
        .MAX_CMD_CHARS (MAX_CMD_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    ulp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    ulp_back #(
        .DUTY_SCALE (DUTY_SCALE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_out_cmd),
        .o_q_pop         (q_pop),
        .o_tx_valid      (o_tx_valid),
        .i_tx_ready      (i_tx_ready),
        .o_tx_byte       (o_tx_byte),
        .o_last_byte     (o_last_byte),
        .o_led_is_on     (o_led_is_on),
        .o_duty_percent  (o_duty_percent),
        .o_compare_value (o_compare_value)
    );

endmodule : uart_led_pwm_command_parser_top
`default_nettype wire

// ===== rtl/ulp_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulp_cmd_queue
// Two-entry command queue between the parser and the responder.
// ----------------------------------------------------------------------------
module ulp_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  ulp_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output ulp_pkg::t_cmd      o_cmd
);
    import ulp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wr <= ~r_wr;
            if (pop_ok)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    // Checks
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty command queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("command queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");

endmodule : ulp_cmd_queue
`default_nettype wire

// ===== rtl/ulp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulp_front
// Byte parser: gathers command characters, tracks keyword candidates and the
// PWM digits, and queues a decoded command on each '!'.
// ----------------------------------------------------------------------------
module ulp_front #(
    parameter int MAX_CMD_CHARS = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output ulp_pkg::t_cmd      o_q_cmd
);
    import ulp_pkg::*;

    localparam int CW = $clog2(MAX_CMD_CHARS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CMD_CHARS);

    logic [CW-1:0] r_count, n_count;
    logic [3:0]    r_alive, n_alive;
    logic [7:0]    r_acc,   n_acc;
    logic          r_ended, n_ended;
    logic          r_null,  n_null;

    logic          accept;
    logic [3:0]    alive_fin;

    // Drop keywords whose length cannot match a command of n characters
    function automatic logic [3:0] prune_len(input logic [3:0] alive, input logic [CW-1:0] n);
        logic [3:0] a;
        a = alive;
        if (n != CW'(2)) a[KB_ON]     = 1'b0;
        if (n != CW'(3)) a[KB_OFF]    = 1'b0;
        if (n != CW'(6)) a[KB_STATUS] = 1'b0;
        if (n <  CW'(4)) a[KB_PWM]    = 1'b0;
        return a;
    endfunction

    // Drop keywords that disagree with character c at position p
    function automatic logic [3:0] check_kw(input logic [3:0] alive, input logic [CW-1:0] p,
                                            input logic [7:0] c);
        logic on_ok;
        logic off_ok;
        logic st_ok;
        logic pwm_ok;
        on_ok  = 1'b0;
        off_ok = 1'b0;
        st_ok  = 1'b0;
        pwm_ok = 1'b1;   // characters past the prefix belong to the value
        case (p)
            CW'(0): begin
                on_ok  = (c == "O");
                off_ok = (c == "O");
                st_ok  = (c == "S");
                pwm_ok = (c == "P");
            end
            CW'(1): begin
                on_ok  = (c == "N");
                off_ok = (c == "F");
                st_ok  = (c == "t");
                pwm_ok = (c == "W");
            end
            CW'(2): begin
                off_ok = (c == "F");
                st_ok  = (c == "a");
                pwm_ok = (c == "M");
            end
            CW'(3): begin
                st_ok  = (c == "t");
                pwm_ok = (c == ":");
            end
            CW'(4): st_ok = (c == "u");
            CW'(5): st_ok = (c == "s");
            default: ;
        endcase
        return alive & {pwm_ok, st_ok, off_ok, on_ok};
    endfunction

    assign o_rx_ready = !i_q_full;
    assign accept     = i_rx_valid && o_rx_ready;
    assign alive_fin  = r_null ? r_alive : prune_len(r_alive, r_count);

    // Parse state update and command decode
    always_comb begin
        n_count = r_count;
        n_alive = r_alive;
        n_acc   = r_acc;
        n_ended = r_ended;
        n_null  = r_null;
        o_q_push = 1'b0;
        o_q_cmd.value = r_acc[6:0];
        if (alive_fin[KB_ON])          o_q_cmd.kind = CMD_ON;
        else if (alive_fin[KB_OFF])    o_q_cmd.kind = CMD_OFF;
        else if (alive_fin[KB_STATUS]) o_q_cmd.kind = CMD_STATUS;
        else if (alive_fin[KB_PWM])    o_q_cmd.kind = (r_acc <= 8'(DUTY_MAX)) ? CMD_PWM_SET
                                                                              : CMD_PWM_ERR;
        else                           o_q_cmd.kind = CMD_UNKNOWN;

        if (accept && i_rx_byte != CH_CR && i_rx_byte != CH_LF) begin
            if (i_rx_byte == CH_BANG) begin
                // terminator: hand off and restart the parse
                o_q_push = 1'b1;
                n_count = '0;
                n_alive = KW_ALL;
                n_acc   = '0;
                n_ended = 1'b0;
                n_null  = 1'b0;
            end else if (r_count >= MAX_CNT) begin
                // overflow: clear, drop the character
                n_count = '0;
                n_alive = KW_ALL;
                n_acc   = '0;
                n_ended = 1'b0;
                n_null  = 1'b0;
            end else begin
                n_count = r_count + CW'(1);
                if (!r_null) begin
                    if (i_rx_byte == CH_NUL) begin
                        n_alive = prune_len(r_alive, r_count);
                        n_null  = 1'b1;
                        n_ended = 1'b1;
                    end else begin
                        n_alive = check_kw(r_alive, r_count, i_rx_byte);
                        if (r_count >= CW'(4) && !r_ended) begin
                            if (i_rx_byte >= CH_DIG0 && i_rx_byte <= CH_DIG9) begin
                                n_acc = (r_acc << 3) + (r_acc << 1) + {4'd0, i_rx_byte[3:0]};
                            end else begin
                                n_ended = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_alive <= KW_ALL;
            r_acc   <= '0;
            r_ended <= 1'b0;
            r_null  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_alive <= n_alive;
            r_acc   <= n_acc;
            r_ended <= n_ended;
            r_null  <= n_null;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT) else $error("character count above limit");
    a_null_ends_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_null |-> r_ended) else $error("zero byte seen but digits still open");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full) else $error("command pushed into full queue");
    a_bang_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_count == '0 && r_alive == KW_ALL))
        else $error("parse state not cleared after terminator");

endmodule : ulp_front
`default_nettype wire

// ===== rtl/ulp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ulp_back
// Responder: applies each queued command to the LED and duty state and
// streams the response text one byte per beat, segment by segment.
// ----------------------------------------------------------------------------
module ulp_back #(
    parameter int DUTY_SCALE = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  ulp_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_tx_valid,
    input  wire logic          i_tx_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte,
    output logic               o_led_is_on,
    output logic [6:0]         o_duty_percent,
    output logic [9:0]         o_compare_value
);
    import ulp_pkg::*;

    // Response text segments
    typedef enum logic [3:0] {
        SEG_LED_ON,
        SEG_LED_OFF,
        SEG_LED_COLON,
        SEG_ON,
        SEG_OFF,
        SEG_PWM_COLON,
        SEG_PWM_EQ,
        SEG_NUM,
        SEG_PCT,
        SEG_PWM_ERR,
        SEG_UNKNOWN
    } t_seg;

    typedef logic [17*8-1:0] t_text;

    localparam t_text TXT_LED_ON    = t_text'({"LED ON", CH_CR, CH_LF});
    localparam t_text TXT_LED_OFF   = t_text'({"LED OFF", CH_CR, CH_LF});
    localparam t_text TXT_LED_COLON = t_text'("LED: ");
    localparam t_text TXT_ON        = t_text'({"ON", CH_CR, CH_LF});
    localparam t_text TXT_OFF       = t_text'({"OFF", CH_CR, CH_LF});
    localparam t_text TXT_PWM_COLON = t_text'("PWM: ");
    localparam t_text TXT_PWM_EQ    = t_text'("PWM = ");
    localparam t_text TXT_PCT       = t_text'({"%", CH_CR, CH_LF});
    localparam t_text TXT_PWM_ERR   = t_text'({"PWM ERROR", CH_CR, CH_LF});
    localparam t_text TXT_UNKNOWN   = t_text'({"UNKNOWN COMMAND", CH_CR, CH_LF});

    function automatic logic [4:0] seg_len(input t_seg seg);
        case (seg)
            SEG_LED_ON:    return 5'd8;
            SEG_LED_OFF:   return 5'd9;
            SEG_LED_COLON: return 5'd5;
            SEG_ON:        return 5'd4;
            SEG_OFF:       return 5'd5;
            SEG_PWM_COLON: return 5'd5;
            SEG_PWM_EQ:    return 5'd6;
            SEG_PCT:       return 5'd3;
            SEG_PWM_ERR:   return 5'd11;
            SEG_UNKNOWN:   return 5'd17;
            default:       return 5'd1;
        endcase
    endfunction

    // Character pos of a fixed segment (text stored right-justified)
    function automatic logic [7:0] text_byte(input t_seg seg, input logic [4:0] pos);
        t_text      s;
        logic [4:0] idx;
        case (seg)
            SEG_LED_ON:    s = TXT_LED_ON;
            SEG_LED_OFF:   s = TXT_LED_OFF;
            SEG_LED_COLON: s = TXT_LED_COLON;
            SEG_ON:        s = TXT_ON;
            SEG_OFF:       s = TXT_OFF;
            SEG_PWM_COLON: s = TXT_PWM_COLON;
            SEG_PWM_EQ:    s = TXT_PWM_EQ;
            SEG_PCT:       s = TXT_PCT;
            SEG_PWM_ERR:   s = TXT_PWM_ERR;
            SEG_UNKNOWN:   s = TXT_UNKNOWN;
            default:       s = '0;
        endcase
        idx = seg_len(seg) - 5'd1 - pos;
        return s[8*idx +: 8];
    endfunction

    // Segment sequence of each response
    function automatic t_seg plan_seg(input t_cmd_kind kind, input logic [2:0] step,
                                      input logic led);
        case (kind)
            CMD_ON:  return SEG_LED_ON;
            CMD_OFF: return SEG_LED_OFF;
            CMD_STATUS: begin
                case (step)
                    3'd0:    return SEG_LED_COLON;
                    3'd1:    return led ? SEG_ON : SEG_OFF;
                    3'd2:    return SEG_PWM_COLON;
                    3'd3:    return SEG_NUM;
                    default: return SEG_PCT;
                endcase
            end
            CMD_PWM_SET: begin
                case (step)
                    3'd0:    return SEG_PWM_EQ;
                    3'd1:    return SEG_NUM;
                    default: return SEG_PCT;
                endcase
            end
            CMD_PWM_ERR: return SEG_PWM_ERR;
            default:     return SEG_UNKNOWN;
        endcase
    endfunction

    function automatic logic [2:0] plan_steps(input t_cmd_kind kind);
        case (kind)
            CMD_STATUS:  return 3'd5;
            CMD_PWM_SET: return 3'd3;
            default:     return 3'd1;
        endcase
    endfunction

    t_back_state r_state, n_state;
    t_cmd_kind   r_kind,  n_kind;
    logic [2:0]  r_step,  n_step;
    logic [4:0]  r_pos,   n_pos;
    logic        r_led,   n_led;
    logic [6:0]  r_duty,  n_duty;
    logic [7:0]  r_num [3];
    logic [7:0]  n_num [3];
    logic [1:0]  r_num_len, n_num_len;

    logic        r_tx_valid, n_tx_valid;
    logic [7:0]  r_tx_byte,  n_tx_byte;
    logic        r_last,     n_last;
    logic        r_led_out,  n_led_out;
    logic [6:0]  r_duty_out, n_duty_out;
    logic [9:0]  r_cmp_out,  n_cmp_out;

    logic        slot_free;
    t_seg        cur_seg;
    logic [4:0]  cur_len;
    logic [7:0]  cur_byte;
    logic        seg_end;
    logic        resp_end;
    logic [16:0] cmp_prod;
    logic [9:0]  cmp_now;
    logic [6:0]  num_src;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [3:0]  ones;

    assign slot_free = !r_tx_valid || i_tx_ready;
    assign cur_seg   = plan_seg(r_kind, r_step, r_led);
    assign cur_len   = (cur_seg == SEG_NUM) ? {3'd0, r_num_len} : seg_len(cur_seg);
    assign cur_byte  = (cur_seg == SEG_NUM) ? r_num[r_pos[1:0]] : text_byte(cur_seg, r_pos);
    assign seg_end   = (r_pos == cur_len - 5'd1);
    assign resp_end  = seg_end && (r_step == plan_steps(r_kind) - 3'd1);

    // Timer compare from the current LED and duty
    assign cmp_prod = 17'(r_duty) * 17'(DUTY_SCALE);
    assign cmp_now  = (r_led && r_duty != 7'd0) ? cmp_prod[9:0] : 10'd0;

    // Decimal digits of the number to print, tens by reciprocal multiply
    assign num_src   = (i_q_cmd.kind == CMD_PWM_SET) ? i_q_cmd.value : r_duty;
    assign tens_prod = 15'(num_src) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones_full = num_src - ({3'd0, tens} * 7'd10);
    assign ones      = ones_full[3:0];

    // Sequencer next state and output beat
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_step    = r_step;
        n_pos     = r_pos;
        n_led     = r_led;
        n_duty    = r_duty;
        n_num     = r_num;
        n_num_len = r_num_len;
        n_tx_valid = r_tx_valid && !i_tx_ready;
        n_tx_byte  = r_tx_byte;
        n_last     = r_last;
        n_led_out  = r_led_out;
        n_duty_out = r_duty_out;
        n_cmp_out  = r_cmp_out;
        o_q_pop    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_kind  = i_q_cmd.kind;
                    n_step  = 3'd0;
                    n_pos   = 5'd0;
                    case (i_q_cmd.kind)
                        CMD_ON:      n_led  = 1'b1;
                        CMD_OFF:     n_led  = 1'b0;
                        CMD_PWM_SET: n_duty = i_q_cmd.value;
                        default: ;
                    endcase
                    if (num_src >= DUTY_MAX) begin
                        n_num[0]  = "1";
                        n_num[1]  = "0";
                        n_num[2]  = "0";
                        n_num_len = 2'd3;
                    end else if (tens != 4'd0) begin
                        n_num[0]  = CH_DIG0 | {4'd0, tens};
                        n_num[1]  = CH_DIG0 | {4'd0, ones};
                        n_num[2]  = CH_DIG0;
                        n_num_len = 2'd2;
                    end else begin
                        n_num[0]  = CH_DIG0 | {4'd0, ones};
                        n_num[1]  = CH_DIG0;
                        n_num[2]  = CH_DIG0;
                        n_num_len = 2'd1;
                    end
                    n_state = BK_SEND;
                end
            end
            BK_SEND: begin
                if (slot_free) begin
                    n_tx_valid = 1'b1;
                    n_tx_byte  = cur_byte;
                    n_last     = resp_end;
                    n_led_out  = r_led;
                    n_duty_out = r_duty;
                    n_cmp_out  = cmp_now;
                    if (seg_end) begin
                        n_pos  = 5'd0;
                        n_step = r_step + 3'd1;
                        if (resp_end) n_state = BK_IDLE;
                    end else begin
                        n_pos = r_pos + 5'd1;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Control and LED/duty state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_kind     <= CMD_UNKNOWN;
            r_step     <= 3'd0;
            r_pos      <= 5'd0;
            r_led      <= 1'b0;
            r_duty     <= DUTY_RESET;
            r_tx_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_step     <= n_step;
            r_pos      <= n_pos;
            r_led      <= n_led;
            r_duty     <= n_duty;
            r_tx_valid <= n_tx_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_num_len  <= n_num_len;
        r_tx_byte  <= n_tx_byte;
        r_last     <= n_last;
        r_led_out  <= n_led_out;
        r_duty_out <= n_duty_out;
        r_cmp_out  <= n_cmp_out;
    end

    assign o_tx_valid      = r_tx_valid;
    assign o_tx_byte       = r_tx_byte;
    assign o_last_byte     = r_last;
    assign o_led_is_on     = r_led_out;
    assign o_duty_percent  = r_duty_out;
    assign o_compare_value = r_cmp_out;

    // Checks
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SEND) |-> (r_step < plan_steps(r_kind)))
        else $error("response segment index past end of plan");
    a_duty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_MAX) else $error("stored duty above 100");
    a_cmp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx_valid && !o_led_is_on) |-> (o_compare_value == 10'd0))
        else $error("compare value nonzero with LED off");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == BK_SEND)) else $error("pop without starting a response");

endmodule : ulp_back
`default_nettype wire
